FILE: src/lcc_pkg.sv
// ---------------------------------------------------------------------------
// lcc_pkg: shared types and constants of the continuation cache
// entry count, index width and the structs passed between the cells and
// the control logic
// ---------------------------------------------------------------------------
package lcc_pkg;

    localparam int ENTRIES  = 16;
    localparam int IDX_W    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int ID_W     = 64;
    localparam int REV_W    = 64;
    localparam int START_W  = 32;
    localparam int HANDLE_W = 32;
    localparam int COUNT_W  = 16;
    localparam int STAMP_W  = 64;

    // scan token, travels one cell per cycle
    typedef struct packed {
        logic                active;
        logic                hit;
        logic [IDX_W-1:0]    hit_idx;
        logic [HANDLE_W-1:0] hit_handle;
        logic [COUNT_W-1:0]  hit_count;
        logic                has_inv;
        logic [IDX_W-1:0]    inv_idx;
        logic                has_vic;
        logic [IDX_W-1:0]    vic_idx;
        logic [STAMP_W-1:0]  vic_stamp;
    } t_token;

    // lookup key, broadcast to every cell
    typedef struct packed {
        logic [ID_W-1:0]    id;
        logic [REV_W-1:0]   rev;
        logic [START_W-1:0] start;
    } t_key;

    // write-back command, broadcast to every cell
    typedef struct packed {
        logic                en;
        logic                fill;
        logic [IDX_W-1:0]    idx;
        logic [HANDLE_W-1:0] handle;
        logic [COUNT_W-1:0]  count;
        logic [STAMP_W-1:0]  stamp;
    } t_write;

endpackage

FILE: src/lcc_cell.sv
// ---------------------------------------------------------------------------
// lcc_cell: one cache entry with its slice of the scan
// holds tag, data, valid and stamp, folds its entry into the passing token
// ---------------------------------------------------------------------------
module lcc_cell (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic [lcc_pkg::IDX_W-1:0] i_index,
    input  lcc_pkg::t_key        i_key,
    input  lcc_pkg::t_token      i_tok,
    input  lcc_pkg::t_write      i_wr,
    output lcc_pkg::t_token      o_tok
);
    import lcc_pkg::*;

    logic                r_valid;
    logic [ID_W-1:0]     r_id;
    logic [REV_W-1:0]    r_rev;
    logic [START_W-1:0]  r_start;
    logic [HANDLE_W-1:0] r_handle;
    logic [COUNT_W-1:0]  r_count;
    logic [STAMP_W-1:0]  r_stamp;
    t_token              r_tok;
    t_token              n_tok;
    logic                w_match;

    assign w_match = r_valid && (r_id == i_key.id) && (r_rev == i_key.rev)
                     && (r_start == i_key.start);

    always_comb begin
        n_tok = i_tok;
        if (i_tok.active && !i_tok.hit) begin
            if (w_match) begin
                n_tok.hit        = 1'b1;
                n_tok.hit_idx    = i_index;
                n_tok.hit_handle = r_handle;
                n_tok.hit_count  = r_count;
            end else if (!r_valid) begin
                n_tok.has_inv = 1'b1;
                n_tok.inv_idx = i_index;
            end else if (!i_tok.has_vic || (r_stamp < i_tok.vic_stamp)) begin
                n_tok.has_vic   = 1'b1;
                n_tok.vic_idx   = i_index;
                n_tok.vic_stamp = r_stamp;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok <= '0;
        end else begin
            r_tok <= n_tok;
        end
    end

    // entry storage, only valid is cleared
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_wr.en && (i_wr.idx == i_index) && i_wr.fill) begin
            r_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.en && (i_wr.idx == i_index)) begin
            r_stamp <= i_wr.stamp;
            if (i_wr.fill) begin
                r_id     <= i_key.id;
                r_rev    <= i_key.rev;
                r_start  <= i_key.start;
                r_handle <= i_wr.handle;
                r_count  <= i_wr.count;
            end
        end
    end

    assign o_tok = r_tok;

endmodule

FILE: src/lru_continuation_cache_unit.sv
// ---------------------------------------------------------------------------
// lru_continuation_cache_unit: fully associative lru continuation cache
// a row of entry cells scanned by a travelling token, then one write-back
// ---------------------------------------------------------------------------
//
//  channel   direction  handshake                 payload
//  -------   ---------  ------------------------  ---------------------------
//  request   in         i_in_valid / o_in_ready    key and fill data
//  result    out        o_out_valid / i_out_ready  status, hit, handle, count,
//                                                  evicted
//
//  a transaction launches the token, walks it through the chain of cells,
//  captures it at the end and then does write-back, which also loads the
//  result register
//  reset clears all valid bits and the use clock at once, no clearing pass
//  a result waiting on i_out_ready holds write-back back; the next request
//  is taken as soon as write-back is done, while its result is still held
// ---------------------------------------------------------------------------
module lru_continuation_cache_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [lcc_pkg::ID_W-1:0]      i_function_id,
    input  logic [lcc_pkg::REV_W-1:0]     i_function_revision,
    input  logic [lcc_pkg::START_W-1:0]   i_start_position,
    input  logic [lcc_pkg::HANDLE_W-1:0]  i_fill_handle,
    input  logic [lcc_pkg::COUNT_W-1:0]   i_fill_count,
    input  logic                          i_fill_ok,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic                          o_status,
    output logic                          o_hit,
    output logic [lcc_pkg::HANDLE_W-1:0]  o_code_handle,
    output logic [lcc_pkg::COUNT_W-1:0]   o_prologue_count,
    output logic                          o_evicted
);
    import lcc_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_WB
    } t_state;

    t_state              r_state;
    logic                r_inject;
    t_key                r_key;
    logic [HANDLE_W-1:0] r_fill_handle;
    logic [COUNT_W-1:0]  r_fill_count;
    logic                r_fill_ok;
    logic [STAMP_W-1:0]  r_use_clock;
    t_token              r_tok;

    t_token              w_tok [ENTRIES+1];
    t_write              w_wr;
    logic                w_out_free;
    logic                w_wb_go;
    logic [IDX_W-1:0]    w_victim;
    logic                w_evict;

    // token launched into the first cell with an empty scan state
    always_comb begin
        w_tok[0]        = '0;
        w_tok[0].active = r_inject;
    end

    genvar g;
    generate
        for (g = 0; g < ENTRIES; g++) begin : g_cell
            lcc_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_index (IDX_W'(g)),
                .i_key   (r_key),
                .i_tok   (w_tok[g]),
                .i_wr    (w_wr),
                .o_tok   (w_tok[g+1])
            );
        end
    endgenerate

    assign o_in_ready = (r_state == S_IDLE);
    assign w_out_free = !o_out_valid || i_out_ready;
    assign w_wb_go    = (r_state == S_WB) && w_out_free;

    // victim: last invalid entry, else first one with the least stamp
    always_comb begin
        if (r_tok.has_inv) begin
            w_victim = r_tok.inv_idx;
            w_evict  = 1'b0;
        end else if (r_tok.has_vic) begin
            w_victim = r_tok.vic_idx;
            w_evict  = 1'b1;
        end else begin
            w_victim = '0;
            w_evict  = 1'b0;
        end
    end

    // write-back: stamp refresh on a hit, full entry write on a good fill
    always_comb begin
        w_wr        = '0;
        w_wr.stamp  = r_use_clock;
        w_wr.handle = r_fill_handle;
        w_wr.count  = r_fill_count;
        if (w_wb_go) begin
            if (r_tok.hit) begin
                w_wr.en  = 1'b1;
                w_wr.idx = r_tok.hit_idx;
            end else if (r_fill_ok) begin
                w_wr.en   = 1'b1;
                w_wr.fill = 1'b1;
                w_wr.idx  = w_victim;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_inject    <= 1'b0;
            r_use_clock <= '0;
            o_out_valid <= 1'b0;
        end else begin
            // token goes out in the cycle after a request transaction
            r_inject <= (r_state == S_IDLE) && i_in_valid;
            // result register loads at write-back, empties when taken
            if (w_wb_go) begin
                o_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                o_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_key.id      <= i_function_id;
                        r_key.rev     <= i_function_revision;
                        r_key.start   <= i_start_position;
                        r_fill_handle <= i_fill_handle;
                        r_fill_count  <= i_fill_count;
                        r_fill_ok     <= i_fill_ok;
                        r_use_clock   <= r_use_clock + 1'b1;
                        r_state       <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    // token leaves the last cell
                    if (w_tok[ENTRIES].active) begin
                        r_tok   <= w_tok[ENTRIES];
                        r_state <= S_WB;
                    end
                end
                S_WB: begin
                    if (w_out_free) begin
                        if (r_tok.hit) begin
                            o_status         <= 1'b0;
                            o_hit            <= 1'b1;
                            o_code_handle    <= r_tok.hit_handle;
                            o_prologue_count <= r_tok.hit_count;
                            o_evicted        <= 1'b0;
                        end else if (r_fill_ok) begin
                            o_status         <= 1'b0;
                            o_hit            <= 1'b0;
                            o_code_handle    <= r_fill_handle;
                            o_prologue_count <= r_fill_count;
                            o_evicted        <= w_evict;
                        end else begin
                            o_status         <= 1'b1;
                            o_hit            <= 1'b0;
                            o_code_handle    <= '0;
                            o_prologue_count <= '0;
                            o_evicted        <= 1'b0;
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

FILE: sim/tb_lru_continuation_cache_unit.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_lru_continuation_cache_unit: self-checking bench of the continuation cache
// drives keyed requests with fill data, tracks the lru table on the side and
// compares every result against the expected one, under several idling mixes
// ---------------------------------------------------------------------------

module tb_lru_continuation_cache_unit;
    import lcc_pkg::*;

    typedef struct packed {
        t_key                key;
        logic [HANDLE_W-1:0] handle;
        logic [COUNT_W-1:0]  count;
        logic                ok;
    } t_cache_request;

    typedef struct packed {
        logic                status;
        logic                hit;
        logic [HANDLE_W-1:0] handle;
        logic [COUNT_W-1:0]  count;
        logic                evicted;
    } t_cache_reply;

    // shadow copy of the lru table and the queue of replies it predicts
    class cache_tracker;
        logic [ID_W-1:0]     tag_id    [ENTRIES];
        logic [REV_W-1:0]    tag_rev   [ENTRIES];
        logic [START_W-1:0]  tag_start [ENTRIES];
        logic [HANDLE_W-1:0] held_handle [ENTRIES];
        logic [COUNT_W-1:0]  held_count  [ENTRIES];
        logic [STAMP_W-1:0]  held_stamp  [ENTRIES];
        bit                  occupied  [ENTRIES];
        logic [STAMP_W-1:0]  use_clock;
        t_cache_reply        awaited_replies [$];
        int mismatches;
        int checked;
        int hits;
        int evictions;
        int refused;

        function new();
            for (int i = 0; i < ENTRIES; i++) begin
                tag_id[i]      = '0;
                tag_rev[i]     = '0;
                tag_start[i]   = '0;
                held_handle[i] = '0;
                held_count[i]  = '0;
                held_stamp[i]  = '0;
                occupied[i]    = 1'b0;
            end
            use_clock  = '0;
            mismatches = 0;
            checked    = 0;
            hits       = 0;
            evictions  = 0;
            refused    = 0;
        endfunction

        // one accepted request: update the table and queue the reply it causes
        function void take_request(t_cache_request req);
            t_cache_reply r;
            int victim;
            int spare;
            bit found;
            victim = -1;
            spare  = -1;
            found  = 1'b0;
            r      = '0;
            use_clock = use_clock + 1;
            for (int i = 0; i < ENTRIES && !found; i++) begin
                if (occupied[i] && tag_id[i] == req.key.id && tag_rev[i] == req.key.rev &&
                    tag_start[i] == req.key.start) begin
                    held_stamp[i] = use_clock;
                    r.hit         = 1'b1;
                    r.handle      = held_handle[i];
                    r.count       = held_count[i];
                    found         = 1'b1;
                    hits++;
                end else if (!occupied[i]) begin
                    spare = i;
                end else if (victim < 0 || held_stamp[i] < held_stamp[victim]) begin
                    victim = i;
                end
            end
            if (!found) begin
                if (!req.ok) begin
                    r.status = 1'b1;
                    refused++;
                end else begin
                    if (spare >= 0)
                        victim = spare;
                    if (victim < 0)
                        victim = 0;
                    r.evicted = occupied[victim];
                    if (occupied[victim])
                        evictions++;
                    tag_id[victim]      = req.key.id;
                    tag_rev[victim]     = req.key.rev;
                    tag_start[victim]   = req.key.start;
                    held_handle[victim] = req.handle;
                    held_count[victim]  = req.count;
                    held_stamp[victim]  = use_clock;
                    occupied[victim]    = 1'b1;
                    r.handle = req.handle;
                    r.count  = req.count;
                end
            end
            awaited_replies.push_back(r);
        endfunction

        function void note_failure(string what);
            mismatches++;
            if (mismatches <= 10)
                $display("[%0t] mismatch: %s", $realtime, what);
        endfunction

        // one accepted result, compared with the oldest awaited reply
        function void check_reply(t_cache_reply got);
            t_cache_reply want;
            if (awaited_replies.size() == 0) begin
                note_failure($sformatf(
                    "result with nothing awaited: st=%0b hit=%0b h=%0h c=%0h ev=%0b",
                    got.status, got.hit, got.handle, got.count, got.evicted));
                return;
            end
            want = awaited_replies.pop_front();
            checked++;
            if (got.status !== want.status || got.hit !== want.hit ||
                got.handle !== want.handle || got.count !== want.count ||
                got.evicted !== want.evicted)
                note_failure($sformatf(
                    {"reply %0d exp st=%0b hit=%0b h=%0h c=%0h ev=%0b",
                     " got st=%0b hit=%0b h=%0h c=%0h ev=%0b"},
                    checked, want.status, want.hit, want.handle, want.count, want.evicted,
                    got.status, got.hit, got.handle, got.count, got.evicted));
        endfunction
    endclass

    localparam int POOL_SIZE    = 24;     // a few more keys than entries, so lru churns
    localparam int PHASE_ITEMS  = 170;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = ENTRIES + 8;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_in_valid;
    logic                o_in_ready;
    logic [ID_W-1:0]     i_function_id;
    logic [REV_W-1:0]    i_function_revision;
    logic [START_W-1:0]  i_start_position;
    logic [HANDLE_W-1:0] i_fill_handle;
    logic [COUNT_W-1:0]  i_fill_count;
    logic                i_fill_ok;
    logic                o_out_valid;
    logic                i_out_ready;
    logic                o_status;
    logic                o_hit;
    logic [HANDLE_W-1:0] o_code_handle;
    logic [COUNT_W-1:0]  o_prologue_count;
    logic                o_evicted;

    cache_tracker tracker;
    t_key         key_pool [POOL_SIZE];
    int           sender_idle_pct    = 0;
    int           receiver_stall_pct = 0;
    int           cycle_count        = 0;
    int           sent_requests      = 0;

    lru_continuation_cache_unit dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_in_valid          (i_in_valid),
        .o_in_ready          (o_in_ready),
        .i_function_id       (i_function_id),
        .i_function_revision (i_function_revision),
        .i_start_position    (i_start_position),
        .i_fill_handle       (i_fill_handle),
        .i_fill_count        (i_fill_count),
        .i_fill_ok           (i_fill_ok),
        .o_out_valid         (o_out_valid),
        .i_out_ready         (i_out_ready),
        .o_status            (o_status),
        .o_hit               (o_hit),
        .o_code_handle       (o_code_handle),
        .o_prologue_count    (o_prologue_count),
        .o_evicted           (o_evicted)
    );

    // 4 ns clock
    initial i_clk = 1'b0;
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // result side back-pressure, redrawn every cycle from the current stall rate
    always @(posedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= receiver_stall_pct);
    end

    // result monitor: sampled values are the ones that stood before the edge
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready)
            tracker.check_reply({o_status, o_hit, o_code_handle, o_prologue_count, o_evicted});
    end

    // watchdog, far above the slowest legal run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results still awaited",
                cycle_count, tracker.awaited_replies.size());
            $display("** lru_continuation_cache_unit: FAILED **");
            $finish;
        end
    end

    // 64-bit value with the extremes favoured now and then
    function automatic logic [63:0] rand_word64();
        case ($urandom_range(9))
            0:       return '0;
            1:       return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function automatic t_key fresh_key();
        t_key k;
        k.id  = rand_word64();
        k.rev = rand_word64();
        case ($urandom_range(9))
            0:       k.start = '0;
            1:       k.start = '1;
            default: k.start = $urandom;
        endcase
        return k;
    endfunction

    function automatic t_cache_request make_request(t_key k, logic [HANDLE_W-1:0] h,
                                                    logic [COUNT_W-1:0] c, logic ok);
        t_cache_request req;
        req.key    = k;
        req.handle = h;
        req.count  = c;
        req.ok     = ok;
        return req;
    endfunction

    // one request transaction: optional idle gap, then hold valid until taken
    task automatic send_request(t_cache_request req);
        while ($urandom_range(99) < sender_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid          <= 1'b1;
        i_function_id       <= req.key.id;
        i_function_revision <= req.key.rev;
        i_start_position    <= req.key.start;
        i_fill_handle       <= req.handle;
        i_fill_count        <= req.count;
        i_fill_ok           <= req.ok;
        @(posedge i_clk);
        while (!o_in_ready)
            @(posedge i_clk);
        tracker.take_request(req);
        sent_requests++;
    endtask

    // short directed walk over the corner cases of the lookup and replacement
    task automatic run_directed();
        t_key zero_key;
        t_key ones_key;
        t_key near_key;
        t_key mid_key;
        zero_key = '0;
        ones_key = '1;
        near_key = ones_key;
        near_key.start = '0;
        // empty table, tags not cleared at reset, but invalid entries must never match
        send_request(make_request(zero_key, 32'h1234_5678, 16'h00ff, 1'b0));
        // zero handle stored like any other, goes into the last invalid slot
        send_request(make_request(zero_key, '0, '0, 1'b1));
        // hit with a failed fill: fill data ignored, status stays clear
        send_request(make_request(zero_key, '1, '1, 1'b0));
        send_request(make_request(ones_key, '1, '1, 1'b1));
        send_request(make_request(ones_key, 32'h0bad_cafe, 16'h5a5a, 1'b0));
        // key differing only in the start position is a miss
        send_request(make_request(near_key, 32'hffff_0000, 16'h8000, 1'b0));
        // fill the remaining slots
        for (int i = 0; i < ENTRIES - 2; i++) begin
            if (i == 6)
                mid_key = fresh_key();
            send_request(make_request(i == 6 ? mid_key : fresh_key(), $urandom,
                                      COUNT_W'($urandom_range(65535)), 1'b1));
        end
        // full table: evicts the oldest stamp, the all-zero key
        send_request(make_request(near_key, 32'h8000_0001, 16'h0001, 1'b1));
        send_request(make_request(zero_key, 32'h0000_0001, 16'h7fff, 1'b0));
        send_request(make_request(mid_key, '0, '0, 1'b0));
        send_request(make_request(ones_key, '0, '0, 1'b1));
    endtask

    // random traffic, mostly reuse of a small key pool so hits and lru
    // evictions dominate, with near misses and fresh keys as noise
    task automatic run_random(int n);
        t_cache_request req;
        t_key k;
        int sel;
        for (int i = 0; i < n; i++) begin
            sel = $urandom_range(99);
            k   = key_pool[$urandom_range(POOL_SIZE - 1)];
            if (sel >= 90) begin
                k = fresh_key();
            end else if (sel >= 72) begin
                case ($urandom_range(2))
                    0:       k.id    = k.id ^ (64'd1 << $urandom_range(ID_W - 1));
                    1:       k.rev   = k.rev ^ (64'd1 << $urandom_range(REV_W - 1));
                    default: k.start = k.start ^ (32'd1 << $urandom_range(START_W - 1));
                endcase
            end
            req.key = k;
            case ($urandom_range(9))
                0:       req.handle = '0;
                1:       req.handle = '1;
                default: req.handle = $urandom;
            endcase
            case ($urandom_range(9))
                0:       req.count = '0;
                1:       req.count = '1;
                default: req.count = COUNT_W'($urandom_range(65535));
            endcase
            req.ok = ($urandom_range(99) < 85);
            send_request(req);
        end
    endtask

    task automatic refresh_pool(int n);
        for (int i = 0; i < n; i++)
            key_pool[$urandom_range(POOL_SIZE - 1)] = fresh_key();
    endtask

    initial begin
        tracker = new();
        i_rst_n             <= 1'b0;
        i_in_valid          <= 1'b0;
        i_function_id       <= '0;
        i_function_revision <= '0;
        i_start_position    <= '0;
        i_fill_handle       <= '0;
        i_fill_count        <= '0;
        i_fill_ok           <= 1'b0;
        for (int i = 0; i < POOL_SIZE; i++)
            key_pool[i] = fresh_key();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // phase one: back to back, directed cases first
        run_directed();
        run_random(PHASE_ITEMS);

        // phase two: request side idles often
        sender_idle_pct = 58;
        refresh_pool(8);
        run_random(PHASE_ITEMS);

        // phase three: result side stalls often
        sender_idle_pct    = 0;
        receiver_stall_pct = 58;
        refresh_pool(8);
        run_random(PHASE_ITEMS);

        // phase four: both sides idle now and then
        sender_idle_pct    = 24;
        receiver_stall_pct = 24;
        refresh_pool(8);
        run_random(PHASE_ITEMS);
        i_in_valid <= 1'b0;

        // drain, then let a full transaction's worth of cycles pass
        while (tracker.awaited_replies.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("%0d requests over four idling mixes, %0d results checked",
            sent_requests, tracker.checked);
        $display("hits %0d, lru evictions %0d, refused fills %0d, mismatches %0d",
            tracker.hits, tracker.evictions, tracker.refused, tracker.mismatches);
        if (tracker.mismatches == 0 && tracker.awaited_replies.size() == 0)
            $display("** lru_continuation_cache_unit: PASSED **");
        else
            $display("** lru_continuation_cache_unit: FAILED **");
        $finish;
    end

endmodule

FILE: sim.f
src/lcc_pkg.sv
src/lcc_cell.sv
src/lru_continuation_cache_unit.sv
sim/tb_lru_continuation_cache_unit.sv
